### sv/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge out of reset
`define TCW_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");

// Same-cycle implication
`define TCW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### sv/tcw_pkg.sv
// Types and constants of the text console writer.
// No dependencies; used by the channel interfaces and the top level.
package tcw_pkg;

  // Screen geometry
  localparam int ROW_COUNT    = 25;
  localparam int COLUMN_COUNT = 80;
  localparam int CELL_TOTAL   = ROW_COUNT * COLUMN_COUNT;

  // Field widths of the channels
  localparam int FUNC_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int FIELD_W = 11;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Internal widths
  localparam int IDX_W = $clog2(CELL_TOTAL);
  localparam int CNT_W = $clog2(CELL_TOTAL + 1);
  localparam int COL_W = $clog2(COLUMN_COUNT);

  // Fixed positions on the screen
  localparam logic [IDX_W-1:0] LAST_ROW_START = IDX_W'(CELL_TOTAL - COLUMN_COUNT);
  localparam logic [IDX_W-1:0] LAST_CELL      = IDX_W'(CELL_TOTAL - 1);
  localparam logic [CNT_W-1:0] COPY_START     = CNT_W'(COLUMN_COUNT);
  localparam logic [CNT_W-1:0] COPY_END       = CNT_W'(CELL_TOTAL);
  localparam logic [CNT_W-1:0] COPY_LAG       = CNT_W'(COLUMN_COUNT + 1);
  localparam logic [COL_W-1:0] COL_LAST       = COL_W'(COLUMN_COUNT - 1);

  // Character codes
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] NULL_CODE    = 8'h00;

  // Register reset values
  localparam logic [ATTR_W-1:0] PRINT_ATTR_RST = 8'h02;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h07;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRINT_ATTR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 2'd1;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUT   = 2'd0,
    FN_CLEAR = 2'd1,
    FN_ERASE = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } state_t;

endpackage

### sv/tcw_in_if.sv
// Command channel of the text console writer.
// Depends on tcw_pkg for field widths.
interface tcw_in_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAR_W-1:0]  char_code;
  logic [FIELD_W-1:0] cell_index;

  modport source (output valid, func, char_code, cell_index, input ready);
  modport sink   (input valid, func, char_code, cell_index, output ready);
endinterface

### sv/tcw_out_if.sv
// Result channel of the text console writer.
// Depends on tcw_pkg for field widths.
interface tcw_out_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] cursor_cell;
  logic [CHAR_W-1:0]  read_char;
  logic [ATTR_W-1:0]  read_attr;
  logic               scrolled;

  modport source (output valid, cursor_cell, read_char, read_attr, scrolled, input ready);
  modport sink   (input valid, cursor_cell, read_char, read_attr, scrolled, output ready);
endinterface

### sv/tcw_cfg_if.sv
// Register write channel of the text console writer.
// Depends on tcw_pkg for field widths.
interface tcw_cfg_if import tcw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/text_console_writer.sv
// Text console writer: screen memory, cursor and the scroll/clear sequencer.
// Depends on tcw_pkg, the tcw_*_if channel interfaces and assert_macros.svh.
//
//   channel  | dir | beat carries
//   ---------+-----+----------------------------------------------
//   in_ch    | in  | func, char_code, cell_index
//   out_ch   | out | cursor_cell, read_char, read_attr, scrolled
//   cfg_ch   | in  | index (0 print_attr, 1 blank_attr), data
//
// Put, newline and erase load their result directly; read loads it from the
// registered memory read. Scroll copies rows up in one pass with a read and a
// write per cycle, then blanks the last row. Clear blanks every cell.
// rst_n (synchronous) homes the cursor and restores the register defaults;
// the screen memory is undefined until the first clear.
// A new command is taken once the sequencer is idle and the result slot is free
// or being emptied; cfg_ch is always ready.
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  // Screen memory, character in the low byte
  logic [CELL_W-1:0] mem [CELL_TOTAL];
  logic [CELL_W-1:0] rdata_r;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]  cursor_r, cursor_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  rd_r, rd_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  fill_r, fill_nxt;
  logic              scr_r, scr_nxt;
  logic [ATTR_W-1:0] print_attr_r, blank_attr_r;

  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_cursor_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [ATTR_W-1:0]  out_attr_r;
  logic               out_scr_r;

  // Memory port controls
  logic              we_c, re_c;
  logic [IDX_W-1:0]  wa_c, ra_c;
  logic [CELL_W-1:0] wd_c;

  // Result load controls
  logic              load_c;
  logic [CHAR_W-1:0] ld_char_c;
  logic [ATTR_W-1:0] ld_attr_c;
  logic              ld_scr_c;

  // Command decode
  logic  in_fire, out_fire, cfg_fire;
  func_t func_c;
  logic  code_nz_c, is_nl_c, put_scroll_c, rd_ok_c;

  assign in_ch.ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign func_c       = func_t'(in_ch.func);
  assign code_nz_c    = in_ch.char_code != NULL_CODE;
  assign is_nl_c      = in_ch.char_code == NEWLINE_CODE;
  assign put_scroll_c = code_nz_c &&
                        (is_nl_c ? (cursor_r >= LAST_ROW_START) : (cursor_r == LAST_CELL));
  assign rd_ok_c      = int'(in_ch.cell_index) < CELL_TOTAL;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (func_c)
            FN_PUT:   if (put_scroll_c) state_nxt = ST_COPY;
            FN_CLEAR: state_nxt = ST_FILL;
            FN_READ:  if (rd_ok_c) state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_COPY: if (rd_r == COPY_END) state_nxt = ST_FILL;
      ST_FILL: if (fill_r == LAST_CELL) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    rd_nxt     = rd_r;
    pend_nxt   = 1'b0;
    fill_nxt   = fill_r;
    scr_nxt    = scr_r;
    we_c       = 1'b0;
    wa_c       = cursor_r;
    wd_c       = {print_attr_r, in_ch.char_code};
    re_c       = 1'b0;
    ra_c       = IDX_W'(in_ch.cell_index);
    load_c     = 1'b0;
    ld_char_c  = '0;
    ld_attr_c  = '0;
    ld_scr_c   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (func_c)
            FN_PUT: begin
              if (code_nz_c) begin
                if (!is_nl_c) begin
                  we_c = 1'b1;
                end
                if (put_scroll_c) begin
                  // jump to the last row and start the row copy
                  cursor_nxt = LAST_ROW_START;
                  col_nxt    = '0;
                  rd_nxt     = COPY_START;
                  scr_nxt    = 1'b1;
                end else if (is_nl_c) begin
                  cursor_nxt = cursor_r - IDX_W'(col_r) + IDX_W'(COLUMN_COUNT);
                  col_nxt    = '0;
                end else begin
                  cursor_nxt = cursor_r + IDX_W'(1);
                  col_nxt    = (col_r == COL_LAST) ? '0 : col_r + COL_W'(1);
                end
              end
              load_c = !put_scroll_c;
            end
            FN_CLEAR: begin
              cursor_nxt = '0;
              col_nxt    = '0;
              fill_nxt   = '0;
              scr_nxt    = 1'b0;
            end
            FN_ERASE: begin
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - IDX_W'(1);
                col_nxt    = (col_r == '0) ? COL_LAST : col_r - COL_W'(1);
                we_c       = 1'b1;
                wa_c       = cursor_r - IDX_W'(1);
                wd_c       = {print_attr_r, SPACE_CODE};
              end
              load_c = 1'b1;
            end
            FN_READ: begin
              // out of range answers zero at once
              re_c   = rd_ok_c;
              load_c = !rd_ok_c;
            end
            default: load_c = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        load_c    = 1'b1;
        ld_char_c = rdata_r[CHAR_W-1:0];
        ld_attr_c = rdata_r[CELL_W-1:CHAR_W];
      end
      ST_COPY: begin
        // read one row ahead, write the previous read back one row up
        if (rd_r != COPY_END) begin
          re_c     = 1'b1;
          ra_c     = rd_r[IDX_W-1:0];
          rd_nxt   = rd_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          fill_nxt = LAST_ROW_START;
        end
        we_c = pend_r;
        wa_c = IDX_W'(rd_r - COPY_LAG);
        wd_c = rdata_r;
      end
      ST_FILL: begin
        we_c     = 1'b1;
        wa_c     = fill_r;
        wd_c     = {blank_attr_r, SPACE_CODE};
        fill_nxt = fill_r + IDX_W'(1);
        if (fill_r == LAST_CELL) begin
          load_c   = 1'b1;
          ld_scr_c = scr_r;
        end
      end
      default: load_c = 1'b0;
    endcase
  end

  assign out_valid_nxt = load_c ? 1'b1 : (out_fire ? 1'b0 : out_valid_r);

  // Screen memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    if (re_c) begin
      rdata_r <= mem[ra_c];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      col_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Registers written over the configuration channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      print_attr_r <= PRINT_ATTR_RST;
      blank_attr_r <= BLANK_ATTR_RST;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        REG_PRINT_ATTR: print_attr_r <= cfg_ch.data;
        REG_BLANK_ATTR: blank_attr_r <= cfg_ch.data;
        default:        print_attr_r <= print_attr_r;
      endcase
    end
  end

  // Sequencer counters and result payload
  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    fill_r <= fill_nxt;
    scr_r  <= scr_nxt;
    if (load_c) begin
      out_cursor_r <= FIELD_W'(cursor_nxt);
      out_char_r   <= ld_char_c;
      out_attr_r   <= ld_attr_c;
      out_scr_r    <= ld_scr_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_cell = out_cursor_r;
  assign out_ch.read_char   = out_char_r;
  assign out_ch.read_attr   = out_attr_r;
  assign out_ch.scrolled    = out_scr_r;

  // Checks
  `TCW_ASSERT_ALWAYS(a_cursor_range, (cursor_r <= LAST_CELL) && (col_r <= COL_LAST))
  `TCW_ASSERT_NEXT(a_read_result, state_r == ST_READ, out_valid_r)
  `TCW_ASSERT_IMPL(a_slot_free_busy, (state_r == ST_COPY) || (state_r == ST_FILL), !out_valid_r)
  `TCW_ASSERT_IMPL(a_copy_last_row, state_r == ST_COPY, cursor_r == LAST_ROW_START)

endmodule
